>>> design/crc_fbd_pkg.sv
// shared types, codes and the crc step function of the frame byte decoder
package crc_fbd_pkg;

  // result event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_GOOD    = 3'd2;
  localparam logic [2:0] EV_CRCERR  = 3'd3;
  localparam logic [2:0] EV_BADLEN  = 3'd4;
  localparam logic [2:0] EV_BADEND  = 3'd5;

  // input operation codes
  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT    = 8'd3;

  // register reset values
  localparam logic [7:0]  START_BYTE_RST  = 8'hAA;
  localparam logic [7:0]  END_BYTE_RST    = 8'h55;
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd64;
  localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef logic [7:0]            byte_t;
  typedef logic [15:0]           crc_t;
  typedef logic [31:0]           count_t;
  typedef logic [2:0]            event_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // crc-16-ccitt over one byte, msb first
  function automatic crc_t crc_add(input crc_t crc, input byte_t b);
    crc_t c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/crc_fbd_ifs.sv
// channel interfaces of the frame byte decoder: input, result and configuration

// received byte channel
interface crc_fbd_in_if;
  logic                valid;
  logic                ready;
  logic                operation;
  crc_fbd_pkg::byte_t  data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// result channel
interface crc_fbd_out_if;
  logic                 valid;
  logic                 ready;
  crc_fbd_pkg::event_t  event_res;
  crc_fbd_pkg::byte_t   payload_byte;
  crc_fbd_pkg::byte_t   payload_index;
  crc_fbd_pkg::byte_t   msg_type;
  crc_fbd_pkg::byte_t   sequence_number;
  crc_fbd_pkg::byte_t   frame_length;
  crc_fbd_pkg::count_t  bytes_seen;
  crc_fbd_pkg::count_t  good_frames;
  crc_fbd_pkg::count_t  crc_failures;
  crc_fbd_pkg::count_t  resync_count;

  modport source (output valid, output event_res, output payload_byte, output payload_index,
                  output msg_type, output sequence_number, output frame_length,
                  output bytes_seen, output good_frames, output crc_failures,
                  output resync_count, input ready);
  modport sink   (input valid, input event_res, input payload_byte, input payload_index,
                  input msg_type, input sequence_number, input frame_length,
                  input bytes_seen, input good_frames, input crc_failures,
                  input resync_count, output ready);
endinterface

// configuration write channel
interface crc_fbd_cfg_if;
  logic                   valid;
  logic                   ready;
  crc_fbd_pkg::cfg_idx_t  reg_index;
  crc_fbd_pkg::cfg_data_t wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> design/crc_frame_byte_decoder_unit.sv
// top level of the frame byte decoder: byte parser, crc check and counters
//
// Use: each input transaction carries one received byte (operation feed) or a
// restart request that sends the parser back to hunting for the start byte.
// Frames are start, length, type, sequence, payload, crc high, crc low, end.
// Every input transaction gives exactly one result transaction with an event
// code (none, payload byte, frame good, crc error, bad length, bad end) and
// the held header fields and the four 32-bit counters after that byte.
// Configuration writes (start byte, end byte, payload limit, crc seed) go
// through the cfg channel, which is always ready; write only while idle.
// Path: the input register takes the byte when it is accepted, and the result
// register takes the result from it once the result channel can move on.
// Rate: one byte per cycle unless out_ch.ready stalls; the incremental crc step
// and the parser update sit in the single logic stage between those two registers.
// Reset: registers return to their defaults, the parser hunts for the start
// byte, the crc is loaded with its default seed and all counters clear.
// Stall: a result waiting on out_ch.ready is held steady; one more input is
// taken into the input register, after which in_ch.ready stays low.
module crc_frame_byte_decoder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  crc_fbd_in_if.sink            in_ch,
  crc_fbd_out_if.source         out_ch,
  crc_fbd_cfg_if.sink           cfg_ch
);
  import crc_fbd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT, PH_LEN, PH_TYPE, PH_SEQ, PH_PAY, PH_CRCH, PH_CRCL, PH_END
  } phase_t;

  // configuration registers
  byte_t start_byte_r, end_byte_r, max_payload_r;
  crc_t  crc_init_r;

  // input register
  logic  in_vld_r;
  logic  in_op_r;
  byte_t in_byte_r;

  // parser state
  phase_t phase_r, phase_nxt;
  byte_t  byte_pos_r, byte_pos_nxt;
  byte_t  len_r, len_nxt;
  byte_t  type_r, type_nxt;
  byte_t  seq_r, seq_nxt;
  crc_t   crc_r, crc_nxt;
  crc_t   crc_rx_r, crc_rx_nxt;
  count_t byte_cnt_r, byte_cnt_nxt;
  count_t good_cnt_r, good_cnt_nxt;
  count_t crcerr_cnt_r, crcerr_cnt_nxt;
  count_t resync_cnt_r, resync_cnt_nxt;

  // result register
  logic   out_vld_r;
  event_t ev_r, ev_nxt;
  byte_t  pay_byte_r, pay_byte_nxt;
  byte_t  pay_idx_r, pay_idx_nxt;

  logic  advance;
  logic  step;
  crc_t  crc_upd;
  byte_t pos_inc;

  assign advance = !out_vld_r || out_ch.ready;
  assign step    = in_vld_r && advance;
  assign in_ch.ready  = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= START_BYTE_RST;
      end_byte_r    <= END_BYTE_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
      crc_init_r    <= CRC_INIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_START_BYTE:  start_byte_r  <= cfg_ch.wdata[7:0];
        CFG_END_BYTE:    end_byte_r    <= cfg_ch.wdata[7:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_ch.wdata[7:0];
        CFG_CRC_INIT:    crc_init_r    <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // input register, refilled whenever it empties or moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.ready) begin
      in_op_r   <= in_ch.operation;
      in_byte_r <= in_ch.data_byte;
    end
  end

  assign crc_upd = crc_add(crc_r, in_byte_r);
  assign pos_inc = byte_pos_r + 8'd1;

  // parser next state and result
  always_comb begin
    phase_nxt      = phase_r;
    byte_pos_nxt   = byte_pos_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    seq_nxt        = seq_r;
    crc_nxt        = crc_r;
    crc_rx_nxt     = crc_rx_r;
    byte_cnt_nxt   = byte_cnt_r;
    good_cnt_nxt   = good_cnt_r;
    crcerr_cnt_nxt = crcerr_cnt_r;
    resync_cnt_nxt = resync_cnt_r;
    ev_nxt         = EV_NONE;
    pay_byte_nxt   = 8'd0;
    pay_idx_nxt    = 8'd0;
    if (in_op_r == OP_RESTART) begin
      phase_nxt    = PH_WAIT;
      byte_pos_nxt = 8'd0;
    end else begin
      byte_cnt_nxt = byte_cnt_r + 32'd1;
      case (phase_r)
        PH_WAIT: begin
          if (in_byte_r == start_byte_r) begin
            phase_nxt = PH_LEN;
            crc_nxt   = crc_init_r;
          end
        end
        PH_LEN: begin
          if (in_byte_r > max_payload_r) begin
            resync_cnt_nxt = resync_cnt_r + 32'd1;
            phase_nxt      = PH_WAIT;
            ev_nxt         = EV_BADLEN;
          end else begin
            len_nxt   = in_byte_r;
            crc_nxt   = crc_upd;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt  = in_byte_r;
          crc_nxt   = crc_upd;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt      = in_byte_r;
          crc_nxt      = crc_upd;
          byte_pos_nxt = 8'd0;
          phase_nxt    = (len_r == 8'd0) ? PH_CRCH : PH_PAY;
        end
        PH_PAY: begin
          ev_nxt       = EV_PAYLOAD;
          pay_byte_nxt = in_byte_r;
          pay_idx_nxt  = byte_pos_r;
          crc_nxt      = crc_upd;
          byte_pos_nxt = pos_inc;
          if (pos_inc >= len_r) begin
            phase_nxt = PH_CRCH;
          end
        end
        PH_CRCH: begin
          crc_rx_nxt = {in_byte_r, 8'h00};
          phase_nxt  = PH_CRCL;
        end
        PH_CRCL: begin
          crc_rx_nxt = {crc_rx_r[15:8], in_byte_r};
          phase_nxt  = PH_END;
        end
        default: begin
          phase_nxt = PH_WAIT;
          if (in_byte_r != end_byte_r) begin
            resync_cnt_nxt = resync_cnt_r + 32'd1;
            ev_nxt         = EV_BADEND;
          end else if (crc_r != crc_rx_r) begin
            crcerr_cnt_nxt = crcerr_cnt_r + 32'd1;
            ev_nxt         = EV_CRCERR;
          end else begin
            good_cnt_nxt = good_cnt_r + 32'd1;
            ev_nxt       = EV_GOOD;
          end
        end
      endcase
    end
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      byte_pos_r   <= 8'd0;
      len_r        <= 8'd0;
      type_r       <= 8'd0;
      seq_r        <= 8'd0;
      crc_r        <= CRC_INIT_RST;
      crc_rx_r     <= 16'd0;
      byte_cnt_r   <= 32'd0;
      good_cnt_r   <= 32'd0;
      crcerr_cnt_r <= 32'd0;
      resync_cnt_r <= 32'd0;
      out_vld_r    <= 1'b0;
    end else begin
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (step) begin
        phase_r      <= phase_nxt;
        byte_pos_r   <= byte_pos_nxt;
        len_r        <= len_nxt;
        type_r       <= type_nxt;
        seq_r        <= seq_nxt;
        crc_r        <= crc_nxt;
        crc_rx_r     <= crc_rx_nxt;
        byte_cnt_r   <= byte_cnt_nxt;
        good_cnt_r   <= good_cnt_nxt;
        crcerr_cnt_r <= crcerr_cnt_nxt;
        resync_cnt_r <= resync_cnt_nxt;
      end
    end
    if (step) begin
      ev_r       <= ev_nxt;
      pay_byte_r <= pay_byte_nxt;
      pay_idx_r  <= pay_idx_nxt;
    end
  end

  // result channel; held fields and counters show the state after the byte
  assign out_ch.valid           = out_vld_r;
  assign out_ch.event_res       = ev_r;
  assign out_ch.payload_byte    = pay_byte_r;
  assign out_ch.payload_index   = pay_idx_r;
  assign out_ch.msg_type        = type_r;
  assign out_ch.sequence_number = seq_r;
  assign out_ch.frame_length    = len_r;
  assign out_ch.bytes_seen      = byte_cnt_r;
  assign out_ch.good_frames     = good_cnt_r;
  assign out_ch.crc_failures    = crcerr_cnt_r;
  assign out_ch.resync_count    = resync_cnt_r;

endmodule

>>> design/crc_fbd_checker.sv
// port-level checker of the frame byte decoder and its bind to the top level
module crc_fbd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input crc_fbd_pkg::event_t  out_event_res,
  input crc_fbd_pkg::byte_t   out_payload_byte,
  input crc_fbd_pkg::byte_t   out_payload_index,
  input crc_fbd_pkg::byte_t   out_frame_length
);
  import crc_fbd_pkg::*;

  // a stalled result keeps its event
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  // a payload byte always lies inside its frame length
  a_pay_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_PAYLOAD |-> out_payload_index < out_frame_length)
    else $error("payload index beyond frame length");

  // payload fields read zero on any other event
  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_PAYLOAD |->
      out_payload_byte == 8'd0 && out_payload_index == 8'd0)
    else $error("payload fields set without a payload event");

endmodule

bind crc_frame_byte_decoder_unit crc_fbd_checker u_crc_fbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_event_res     (out_ch.event_res),
  .out_payload_byte  (out_ch.payload_byte),
  .out_payload_index (out_ch.payload_index),
  .out_frame_length  (out_ch.frame_length)
);

>>> sim/crc_frame_byte_decoder_unit_test.sv
// self-checking testbench of the frame byte decoder: directed frames, faults and random traffic
`timescale 1ns / 100ps

module crc_frame_byte_decoder_unit_test;
  import crc_fbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 300;

  typedef enum logic [2:0] {
    HUNT_START, TAKE_LEN, TAKE_TYPE, TAKE_SEQ,
    TAKE_PAYLOAD, TAKE_CRC_HI, TAKE_CRC_LO, TAKE_END
  } parse_phase_t;

  typedef enum int {CLEAN, BAD_CRC, BAD_END, BAD_LEN, CUT_SHORT} frame_fault_t;

  typedef struct {
    event_t ev;
    byte_t  pbyte;
    byte_t  pindex;
    byte_t  mtype;
    byte_t  seqn;
    byte_t  flen;
    count_t n_bytes;
    count_t n_good;
    count_t n_crc_err;
    count_t n_resync;
  } parse_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  crc_fbd_in_if  in_if ();
  crc_fbd_out_if out_if ();
  crc_fbd_cfg_if cfg_if ();

  crc_frame_byte_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // register copies
  byte_t reg_start = START_BYTE_RST;
  byte_t reg_end   = END_BYTE_RST;
  byte_t reg_max   = MAX_PAYLOAD_RST;
  crc_t  reg_seed  = CRC_INIT_RST;

  // parser copy
  parse_phase_t ph       = HUNT_START;
  byte_t        pos_q    = '0;
  byte_t        len_q    = '0;
  byte_t        type_q   = '0;
  byte_t        seq_q    = '0;
  crc_t         crc_acc  = CRC_INIT_RST;
  crc_t         crc_rx   = '0;
  count_t       cnt_bytes  = '0;
  count_t       cnt_good   = '0;
  count_t       cnt_crcerr = '0;
  count_t       cnt_resync = '0;

  parse_rec_t parsed_results[$];
  int         error_count    = 0;
  int         items_sent     = 0;
  int         cycle_count    = 0;
  bit         sender_gaps    = 1'b1;
  bit         receiver_gaps  = 1'b1;
  int         stall_requests = 0;
  int         stall_taken    = 0;
  int         stall_left     = 0;

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** crc_frame_byte_decoder_unit: FAILED **");
      $finish;
    end
  end

  // crc-16-ccitt, one input bit at a time
  function automatic crc_t crc16_step(input crc_t acc, input byte_t b);
    crc_t c;
    logic fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // advance the parser copy by one input transaction
  function automatic parse_rec_t parse_byte(input logic op, input byte_t b);
    parse_rec_t r;
    r.ev     = EV_NONE;
    r.pbyte  = '0;
    r.pindex = '0;
    if (op == OP_RESTART) begin
      ph    = HUNT_START;
      pos_q = '0;
    end else begin
      cnt_bytes = cnt_bytes + 32'd1;
      case (ph)
        HUNT_START: begin
          if (b == reg_start) begin
            ph      = TAKE_LEN;
            crc_acc = reg_seed;
          end
        end
        TAKE_LEN: begin
          if (b > reg_max) begin
            cnt_resync = cnt_resync + 32'd1;
            ph         = HUNT_START;
            r.ev       = EV_BADLEN;
          end else begin
            len_q   = b;
            crc_acc = crc16_step(crc_acc, b);
            ph      = TAKE_TYPE;
          end
        end
        TAKE_TYPE: begin
          type_q  = b;
          crc_acc = crc16_step(crc_acc, b);
          ph      = TAKE_SEQ;
        end
        TAKE_SEQ: begin
          seq_q   = b;
          crc_acc = crc16_step(crc_acc, b);
          pos_q   = '0;
          ph      = (len_q == '0) ? TAKE_CRC_HI : TAKE_PAYLOAD;
        end
        TAKE_PAYLOAD: begin
          r.ev     = EV_PAYLOAD;
          r.pbyte  = b;
          r.pindex = pos_q;
          crc_acc  = crc16_step(crc_acc, b);
          pos_q    = pos_q + 8'd1;
          if (pos_q >= len_q) ph = TAKE_CRC_HI;
        end
        TAKE_CRC_HI: begin
          crc_rx = {b, 8'h00};
          ph     = TAKE_CRC_LO;
        end
        TAKE_CRC_LO: begin
          crc_rx[7:0] = b;
          ph          = TAKE_END;
        end
        default: begin
          ph = HUNT_START;
          if (b != reg_end) begin
            cnt_resync = cnt_resync + 32'd1;
            r.ev       = EV_BADEND;
          end else if (crc_acc != crc_rx) begin
            cnt_crcerr = cnt_crcerr + 32'd1;
            r.ev       = EV_CRCERR;
          end else begin
            cnt_good = cnt_good + 32'd1;
            r.ev     = EV_GOOD;
          end
        end
      endcase
    end
    r.mtype     = type_q;
    r.seqn      = seq_q;
    r.flen      = len_q;
    r.n_bytes   = cnt_bytes;
    r.n_good    = cnt_good;
    r.n_crc_err = cnt_crcerr;
    r.n_resync  = cnt_resync;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // result receiver: random ready with a long hold-off on request
  always @(negedge clk) begin
    if (stall_taken != stall_requests) begin
      stall_taken = stall_requests;
      stall_left  = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (receiver_gaps) begin
      out_if.ready <= ($urandom_range(99) >= 31);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    parse_rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (parsed_results.size() == 0) begin
        $error("result transaction with no prediction waiting");
        error_count++;
      end else begin
        want = parsed_results.pop_front();
        check_field("event_res", 32'(want.ev), 32'(out_if.event_res));
        check_field("payload_byte", 32'(want.pbyte), 32'(out_if.payload_byte));
        check_field("payload_index", 32'(want.pindex), 32'(out_if.payload_index));
        check_field("msg_type", 32'(want.mtype), 32'(out_if.msg_type));
        check_field("sequence_number", 32'(want.seqn), 32'(out_if.sequence_number));
        check_field("frame_length", 32'(want.flen), 32'(out_if.frame_length));
        check_field("bytes_seen", want.n_bytes, out_if.bytes_seen);
        check_field("good_frames", want.n_good, out_if.good_frames);
        check_field("crc_failures", want.n_crc_err, out_if.crc_failures);
        check_field("resync_count", want.n_resync, out_if.resync_count);
      end
    end
  end

  // one input transaction, entered and left at a falling edge
  task automatic send_item(input logic op, input byte_t b);
    if (sender_gaps) begin
      while ($urandom_range(99) < 31) begin
        in_if.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_if.valid     = 1'b1;
    in_if.operation = op;
    in_if.data_byte = b;
    do @(posedge clk); while (!in_if.ready);
    parsed_results.push_back(parse_byte(op, b));
    items_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_if.valid     = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.wdata     = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_START_BYTE:  reg_start = val[7:0];
      CFG_END_BYTE:    reg_end   = val[7:0];
      CFG_MAX_PAYLOAD: reg_max   = val[7:0];
      CFG_CRC_INIT:    reg_seed  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_drained;
    while (parsed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // whole frame with random payload and an optional fault
  task automatic send_frame(input int len, input byte_t mtype, input byte_t seqn,
                            input frame_fault_t fault);
    byte_t frame_q[$];
    crc_t  acc;
    byte_t len_byte;
    byte_t pb;
    int    cut;
    len_byte = byte_t'(len);
    if (fault == BAD_LEN && reg_max == 8'hFF) fault = CLEAN;
    if (fault == BAD_LEN) len_byte = byte_t'($urandom_range(255, int'(reg_max) + 1));
    frame_q.push_back(reg_start);
    frame_q.push_back(len_byte);
    if (fault != BAD_LEN) begin
      acc = crc16_step(reg_seed, len_byte);
      acc = crc16_step(acc, mtype);
      acc = crc16_step(acc, seqn);
      frame_q.push_back(mtype);
      frame_q.push_back(seqn);
      for (int i = 0; i < len; i++) begin
        pb  = byte_t'($urandom);
        acc = crc16_step(acc, pb);
        frame_q.push_back(pb);
      end
      if (fault == BAD_CRC) acc = acc ^ crc_t'($urandom_range(65535, 1));
      frame_q.push_back(acc[15:8]);
      frame_q.push_back(acc[7:0]);
      if (fault == BAD_END) frame_q.push_back(reg_end ^ byte_t'($urandom_range(255, 1)));
      else frame_q.push_back(reg_end);
    end
    cut = (fault == CUT_SHORT) ? $urandom_range(frame_q.size() - 1, 1) : frame_q.size();
    for (int i = 0; i < cut; i++) send_item(OP_FEED, frame_q[i]);
    if (fault == CUT_SHORT) send_item(OP_RESTART, byte_t'($urandom));
  endtask

  // good frames at reset settings, header extremes, zero length
  task automatic test_good_frames;
    send_frame(1, 8'h00, 8'hFF, CLEAN);
    send_frame(0, 8'hFF, 8'h00, CLEAN);
  endtask

  // crc mismatch, wrong end byte, oversized length
  task automatic test_frame_faults;
    send_frame(0, byte_t'($urandom), byte_t'($urandom), BAD_CRC);
    send_frame(0, byte_t'($urandom), byte_t'($urandom), BAD_END);
    send_frame(0, 8'h00, 8'h00, BAD_LEN);
  endtask

  // restart while hunting and in the middle of a frame
  task automatic test_restart;
    send_item(OP_RESTART, 8'hFF);
    send_frame(2, byte_t'($urandom), byte_t'($urandom), CUT_SHORT);
    send_frame(0, byte_t'($urandom), byte_t'($urandom), CLEAN);
  endtask

  // length equal to the limit passes, one above and the top value resync
  task automatic test_length_limit;
    wait_drained;
    write_reg(CFG_MAX_PAYLOAD, 16'd2);
    send_frame(2, byte_t'($urandom), byte_t'($urandom), CLEAN);
    send_item(OP_FEED, reg_start);
    send_item(OP_FEED, 8'd3);
    send_item(OP_FEED, reg_start);
    send_item(OP_FEED, 8'hFF);
  endtask

  // writes between bytes of one frame touch only later frames or later bytes
  task automatic test_midframe_writes;
    crc_t  acc;
    byte_t mtype, seqn, pay, new_end;
    mtype = byte_t'($urandom);
    seqn  = byte_t'($urandom);
    pay   = byte_t'($urandom);
    send_item(OP_FEED, reg_start);
    send_item(OP_FEED, 8'd1);
    acc = crc16_step(reg_seed, 8'd1);
    wait_drained;
    write_reg(CFG_CRC_INIT, cfg_data_t'($urandom));
    write_reg(CFG_MAX_PAYLOAD, 16'd0);
    send_item(OP_FEED, mtype);
    send_item(OP_FEED, seqn);
    send_item(OP_FEED, pay);
    acc = crc16_step(crc16_step(crc16_step(acc, mtype), seqn), pay);
    send_item(OP_FEED, acc[15:8]);
    send_item(OP_FEED, acc[7:0]);
    new_end = reg_end ^ byte_t'($urandom_range(255, 1));
    wait_drained;
    write_reg(CFG_END_BYTE, {8'h00, new_end});
    send_item(OP_FEED, new_end);
    wait_drained;
    write_reg(CFG_MAX_PAYLOAD, {8'h00, MAX_PAYLOAD_RST});
  endtask

  // all registers at their lowest and highest values, unused index ignored
  task automatic test_register_extremes;
    wait_drained;
    write_reg(CFG_START_BYTE, {8'($urandom), 8'h00});
    write_reg(CFG_END_BYTE, {8'($urandom), 8'h00});
    write_reg(CFG_MAX_PAYLOAD, {8'($urandom), 8'h00});
    write_reg(CFG_CRC_INIT, 16'h0000);
    send_frame(0, 8'h00, 8'h00, CLEAN);
    send_frame(0, 8'h00, 8'h00, BAD_LEN);
    wait_drained;
    write_reg(CFG_START_BYTE, {8'($urandom), 8'hFF});
    write_reg(CFG_END_BYTE, {8'($urandom), 8'hFF});
    write_reg(CFG_MAX_PAYLOAD, {8'($urandom), 8'hFF});
    write_reg(CFG_CRC_INIT, 16'hFFFF);
    send_frame(255, 8'hFF, 8'hFF, CLEAN);
    wait_drained;
    write_reg(cfg_idx_t'($urandom_range(255, 4)), cfg_data_t'($urandom));
    send_frame(3, byte_t'($urandom), byte_t'($urandom), CLEAN);
  endtask

  // long result hold-off while input keeps coming, so the input stalls
  task automatic test_backpressure;
    int stop_at;
    bit gaps_saved;
    wait_drained;
    gaps_saved  = sender_gaps;
    sender_gaps = 1'b0;
    stall_requests++;
    stop_at = items_sent + 40;
    while (items_sent < stop_at)
      send_frame($urandom_range((reg_max < 8'd6) ? int'(reg_max) : 6),
                 byte_t'($urandom), byte_t'($urandom), CLEAN);
    sender_gaps = gaps_saved;
    wait_drained;
  endtask

  // mostly well-formed frames with random content, plus faults and line noise
  task automatic test_random_traffic;
    int    target;
    int    pick;
    int    len;
    int    cap;
    byte_t b;
    frame_fault_t fault;
    for (int stage = 0; stage < 4; stage++) begin
      wait_drained;
      case (stage)
        0: begin
          sender_gaps   = 1'b0;
          receiver_gaps = 1'b0;
          write_reg(CFG_START_BYTE, {8'h00, START_BYTE_RST});
          write_reg(CFG_END_BYTE, {8'h00, END_BYTE_RST});
          write_reg(CFG_MAX_PAYLOAD, {8'h00, MAX_PAYLOAD_RST});
          write_reg(CFG_CRC_INIT, CRC_INIT_RST);
        end
        2: begin
          write_reg(CFG_START_BYTE, {8'($urandom), 8'h00});
          write_reg(CFG_END_BYTE, {8'($urandom), 8'hFF});
          write_reg(CFG_MAX_PAYLOAD, {8'($urandom), 8'hFF});
          write_reg(CFG_CRC_INIT, 16'h0000);
        end
        default: begin
          sender_gaps   = 1'b1;
          receiver_gaps = 1'b1;
          write_reg(CFG_START_BYTE, cfg_data_t'($urandom));
          write_reg(CFG_END_BYTE, cfg_data_t'($urandom));
          write_reg(CFG_MAX_PAYLOAD, cfg_data_t'($urandom));
          write_reg(CFG_CRC_INIT, cfg_data_t'($urandom));
          write_reg(cfg_idx_t'($urandom_range(255, 4)), cfg_data_t'($urandom));
        end
      endcase
      target = items_sent + 215;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // frame, occasionally with a fault
          pick = $urandom_range(99);
          if (pick < 72) fault = CLEAN;
          else if (pick < 82) fault = BAD_CRC;
          else if (pick < 89) fault = BAD_END;
          else if (pick < 94) fault = BAD_LEN;
          else fault = CUT_SHORT;
          cap = (reg_max < 8'd10) ? int'(reg_max) : 10;
          len = ($urandom_range(99) < 3) ? $urandom_range(int'(reg_max)) : $urandom_range(cap);
          send_frame(len, byte_t'($urandom), byte_t'($urandom), fault);
        end else if (pick < 88) begin
          // line noise, a stray start byte is followed by a restart
          repeat ($urandom_range(4, 1)) begin
            b = byte_t'($urandom);
            if (b == reg_start && $urandom_range(3) == 0) begin
              send_item(OP_FEED, b);
              send_item(OP_RESTART, byte_t'($urandom));
            end else begin
              send_item(OP_FEED, (b == reg_start) ? ~b : b);
            end
          end
        end else begin
          send_item(OP_RESTART, byte_t'($urandom));
        end
      end
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_FEED;
    in_if.data_byte  = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata     = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_good_frames();
    test_frame_faults();
    test_restart();
    test_length_limit();
    test_midframe_writes();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (8) @(negedge clk);
    if (parsed_results.size() != 0) begin
      $error("%0d predicted results never arrived", parsed_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** crc_frame_byte_decoder_unit: PASSED **");
    end else begin
      $display("** crc_frame_byte_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
